// ===== src/sdmh_pkg.sv =====
// ----------------------------------------------------------------------------
// sdmh_pkg
// Types, constants and the Speck round function for the 64-bit hash unit.
// ----------------------------------------------------------------------------
package sdmh_pkg;

    localparam int          BLOCK_BYTES = 32;
    localparam int          IDX_W       = $clog2(BLOCK_BYTES);
    localparam int          KEY_WORDS   = BLOCK_BYTES / 4;
    localparam int          KEY_ROUNDS  = 28;
    localparam int          RND_W       = $clog2(KEY_ROUNDS + 1);
    localparam logic [31:0] IV_X        = 32'h0118_0011;
    localparam logic [31:0] IV_Y        = 32'h4fc1_1100;
    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam int          CHUNK_BITS  = 15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_PAD,
        S_RUN_D,
        S_RUN_K,
        S_FOLD
    } t_state;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_pair;

    function automatic t_pair speck_round(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] k);
        t_pair r;
        r.a = ({a[7:0], a[31:8]} + b) ^ k;
        r.b = {b[28:0], b[31:29]} ^ r.a;
        return r;
    endfunction

endpackage

// ===== src/speck_davies_meyer_hash64_unit.sv =====
// ----------------------------------------------------------------------------
// speck_davies_meyer_hash64_unit
// Speck64 Davies-Meyer hash, 64-bit digest, one shared round unit.
// Append byte: taken while idle; the byte that fills a block then runs 57
//   alternating data/key rounds through the single round unit and 1 fold.
// Finish: setup, then one pad byte per cycle (up to 40), paused while a block
//   compresses; the last fold waits while an earlier digest is still held.
// Synchronous active-low reset clears count, chain and control; the block
//   buffer is not cleared.
// ----------------------------------------------------------------------------
module speck_davies_meyer_hash64_unit
    import sdmh_pkg::*;
#(
    parameter int COUNT_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] digest_lo, [63:32] digest_hi
);

    localparam int BLK_W = COUNT_BITS - IDX_W + 1;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_count;
    logic [31:0]           r_chain_x, r_chain_y;
    logic [31:0]           r_x, r_y;
    logic [31:0]           r_key [KEY_WORDS];
    logic [RND_W-1:0]      r_rnd;
    logic                  r_fin;
    logic                  r_first;
    logic [BLK_W-1:0]      r_blocks;
    logic [6:0]            r_left;
    logic [3:0]            r_tleft;
    logic [63:0]           r_tail;
    logic                  r_out_vld;
    logic [63:0]           r_out;

    logic                  s_fire, out_free, block_end, byte_we, pad_done;
    logic [7:0]            byte_val;
    logic [31:0]           rd_a, rd_b, rd_k;
    t_pair                 rres;
    logic [IDX_W-1:0]      idx;
    logic [63:0]           b64;
    logic [2:0]            nch;
    logic [6:0]            p7;
    logic [63:0]           tail;

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_vld || m_axis_tready;
    assign idx       = r_count[IDX_W-1:0];
    assign block_end = (idx == {IDX_W{1'b1}});
    assign pad_done  = (r_left == 7'd0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser) begin
                        n_state = S_SETUP;
                    end else if (block_end) begin
                        n_state = S_RUN_D;
                    end
                end
            end
            S_SETUP: n_state = S_PAD;
            S_PAD: begin
                if (block_end) begin
                    n_state = S_RUN_D;
                end
            end
            S_RUN_D: begin
                if (r_rnd == RND_W'(KEY_ROUNDS)) begin
                    n_state = S_FOLD;
                end else begin
                    n_state = S_RUN_K;
                end
            end
            S_RUN_K: n_state = S_RUN_D;
            S_FOLD: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (!pad_done) begin
                    n_state = S_PAD;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs and shared round operands
    always_comb begin
        s_axis_tready = 1'b0;
        byte_we       = 1'b0;
        byte_val      = s_axis_tdata;
        rd_a          = r_x;
        rd_b          = r_y;
        rd_k          = r_key[0];
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                byte_we       = s_axis_tvalid && !s_axis_tuser;
            end
            S_PAD: begin
                byte_we = 1'b1;
                if (r_left > {3'b000, r_tleft}) begin
                    byte_val = r_first ? PAD_MARK : 8'h00;
                end else begin
                    byte_val = r_tail[63:56];
                end
            end
            S_RUN_K: begin
                rd_a = r_key[1];
                rd_b = r_key[0];
                rd_k = 32'(r_rnd);
            end
            default: ;
        endcase
    end

    assign rres = speck_round(rd_a, rd_b, rd_k);

    // padding layout from the block count
    always_comb begin
        b64  = 64'(r_blocks);
        nch  = 3'd1 + 3'(b64[63:CHUNK_BITS] != '0) + 3'(b64[63:2*CHUNK_BITS] != '0)
                    + 3'(b64[63:3*CHUNK_BITS] != '0);
        p7   = 7'd32 - {3'b000, nch, 1'b0} - {2'b00, idx};
        if (p7[6] || (p7 == 7'd0)) begin
            p7 = p7 + 7'd32;
        end
        case (nch)
            3'd1:    tail = {1'b0, b64[14:0], 48'd0};
            3'd2:    tail = {1'b0, b64[29:15], 1'b1, b64[14:0], 32'd0};
            3'd3:    tail = {1'b0, b64[44:30], 1'b1, b64[29:15], 1'b1, b64[14:0], 16'd0};
            default: tail = {1'b0, b64[59:45], 1'b1, b64[44:30], 1'b1, b64[29:15],
                             1'b1, b64[14:0]};
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_chain_x <= IV_X;
            r_chain_y <= IV_Y;
            r_fin     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (byte_we) begin
                r_count <= r_count + COUNT_BITS'(1);
            end
            if (s_fire && s_axis_tuser) begin
                r_fin <= 1'b1;
            end
            if (r_state == S_FOLD) begin
                if (r_fin && pad_done) begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_count   <= '0;
                        r_chain_x <= IV_X;
                        r_chain_y <= IV_Y;
                        r_fin     <= 1'b0;
                    end
                end else begin
                    r_chain_x <= r_chain_x + r_x;
                    r_chain_y <= r_chain_y + r_y;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            r_key[idx[IDX_W-1:2]][{idx[1:0], 3'b000} +: 8] <= byte_val;
            if (block_end) begin
                r_x   <= r_chain_x;
                r_y   <= r_chain_y;
                r_rnd <= '0;
            end
        end
        if (s_fire && s_axis_tuser) begin
            r_blocks <= BLK_W'(r_count >> IDX_W) + BLK_W'(idx != '0);
        end
        if (r_state == S_SETUP) begin
            r_left  <= p7 + {3'b000, nch, 1'b0};
            r_tleft <= {nch, 1'b0};
            r_tail  <= tail;
            r_first <= 1'b1;
        end
        if (r_state == S_PAD) begin
            r_left  <= r_left - 7'd1;
            r_first <= 1'b0;
            if (r_left <= {3'b000, r_tleft}) begin
                r_tail <= {r_tail[55:0], 8'h00};
            end
        end
        if (r_state == S_RUN_D) begin
            r_x <= rres.a;
            r_y <= rres.b;
        end
        if (r_state == S_RUN_K) begin
            r_key[0] <= rres.b;
            for (int i = 1; i < KEY_WORDS - 1; i++) begin
                r_key[i] <= r_key[i+1];
            end
            r_key[KEY_WORDS-1] <= rres.a;
            r_rnd <= r_rnd + RND_W'(1);
        end
        if ((r_state == S_FOLD) && r_fin && pad_done && out_free) begin
            r_out <= {r_chain_y + r_y, r_chain_x + r_x};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    a_key_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN_K) |-> (r_rnd < RND_W'(KEY_ROUNDS)))
        else $error("key schedule ran past its last round");

    a_pad_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (r_left != 7'd0))
        else $error("padding byte issued with nothing left to send");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ((r_count == '0) && (r_chain_x == IV_X) && !r_fin))
        else $error("digest issued without restarting the chain");

endmodule

// ===== dv/speck_davies_meyer_hash64_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// speck_davies_meyer_hash64_unit_tb
// Self-checking bench for the Speck64 Davies-Meyer hash unit. Streams message
// bytes and finish requests, computes every digest with an independent
// model of the hash and compares each output transfer under several
// flow-control mixes, including one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module speck_davies_meyer_hash64_unit_tb;
    import sdmh_pkg::*;

    localparam int   COUNT_W      = 64;
    localparam int   CLK_HALF     = 6;
    localparam int   RST_CYCLES   = 6;
    localparam int   HOLD_CYCLES  = 600;
    localparam int   TAIL_CYCLES  = 200;
    localparam int   PHASE_ITEMS  = 230;
    localparam int   LIMIT_CYCLES = 400_000;
    localparam logic OP_APPEND    = 1'b0;
    localparam logic OP_FINISH    = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
    } t_hash_req;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;       // [7:0] data_byte
    logic        s_axis_tuser  = OP_APPEND;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;                // [31:0] digest_lo, [63:32] digest_hi

    t_hash_req   req_q[$];
    logic [63:0] digest_q[$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   n_queued       = 0;
    int   n_taken        = 0;
    int   n_bytes        = 0;
    int   n_finish       = 0;
    int   n_checked      = 0;
    int   n_errors       = 0;
    logic hold_go        = 1'b0;
    logic hold_on        = 1'b0;

    // hash state as the block should hold it
    logic [7:0]         msg_block [BLOCK_BYTES];
    logic [COUNT_W-1:0] msg_count;
    logic [31:0]        chain_lo;
    logic [31:0]        chain_hi;

    speck_davies_meyer_hash64_unit #(
        .COUNT_BITS(COUNT_W)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic void hash_restart();
        msg_count = '0;
        chain_lo  = IV_X;
        chain_hi  = IV_Y;
    endfunction

    function automatic void speck_mix(inout logic [31:0] a, inout logic [31:0] b,
                                      input logic [31:0] k);
        a = ({a[7:0], a[31:8]} + b) ^ k;
        b = {b[28:0], b[31:29]} ^ a;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [8];
        logic [31:0] x, y, rk, a;
        int          i, j;
        for (i = 0; i < 8; i++) begin
            w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
        end
        x  = chain_lo;
        y  = chain_hi;
        rk = w[0];
        for (i = 0; i < 28; i++) begin
            speck_mix(x, y, rk);
            j = 1 + i % 7;
            a = w[j];
            speck_mix(a, rk, i);
            w[j] = a;
        end
        speck_mix(x, y, rk);
        chain_lo = chain_lo + x;
        chain_hi = chain_hi + y;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        msg_block[msg_count[IDX_W-1:0]] = b;
        msg_count = msg_count + 1'b1;
        if (msg_count[IDX_W-1:0] == '0) begin
            compress_block();
        end
    endfunction

    // pad with the marker, zeros and the block count in 15-bit chunks
    function automatic logic [63:0] finish_digest();
        logic [COUNT_W-1:0] blocks, t;
        logic [15:0]        chunk [4];
        logic [63:0]        dig;
        int                 n, pad, i;
        blocks = (msg_count >> IDX_W) + ((msg_count[IDX_W-1:0] != '0) ? 1 : 0);
        n = 1;
        t = blocks >> CHUNK_BITS;
        while (t != '0 && n < 4) begin
            n++;
            t = t >> CHUNK_BITS;
        end
        t = blocks;
        for (i = n - 1; i >= 0; i--) begin
            chunk[i] = {(i != 0), t[CHUNK_BITS-1:0]};
            t = t >> CHUNK_BITS;
        end
        pad = BLOCK_BYTES - 2 * n - int'(msg_count[IDX_W-1:0]);
        if (pad <= 0) begin
            pad += BLOCK_BYTES;
        end
        absorb_byte(PAD_MARK);
        for (i = 1; i < pad; i++) begin
            absorb_byte(8'h00);
        end
        for (i = 0; i < n; i++) begin
            absorb_byte(chunk[i][15:8]);
            absorb_byte(chunk[i][7:0]);
        end
        dig = {chain_hi, chain_lo};
        hash_restart();
        return dig;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("MISMATCH %s at %0t: got %h, expected %h", what, $time, got, want);
    endtask

    task automatic push_req(input logic func, input logic [7:0] data);
        t_hash_req r;
        r.func = func;
        r.data = data;
        req_q.push_back(r);
        n_queued++;
    endtask

    task automatic queue_message(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            push_req(OP_APPEND, 8'($urandom));
        end
        push_req(OP_FINISH, 8'($urandom));
    endtask

    // bias towards lengths that put the count field at a block edge
    function automatic int pick_length();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 6);
            1: return 32 * $urandom_range(0, 2) + 29 + $urandom_range(0, 3);
            2: return $urandom_range(0, 40);
            default: return $urandom_range(0, 70);
        endcase
    endfunction

    task automatic drain_sent();
        while (n_taken != n_queued) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive
        t_hash_req nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            hash_restart();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                n_taken++;
                if (s_axis_tuser == OP_FINISH) begin
                    digest_q.push_back(finish_digest());
                    n_finish++;
                end else begin
                    absorb_byte(s_axis_tdata);
                    n_bytes++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.func;
                    s_axis_tdata  <= nxt.data;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    s_axis_tuser  <= 1'($urandom);
                    s_axis_tdata  <= 8'($urandom);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        logic [63:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("digest with none pending", m_axis_tdata, '0);
                end else begin
                    want = digest_q.pop_front();
                    if (m_axis_tdata[31:0] !== want[31:0]) begin
                        report_mismatch("digest_lo", m_axis_tdata[31:0], want[31:0]);
                    end
                    if (m_axis_tdata[63:32] !== want[63:32]) begin
                        report_mismatch("digest_hi", m_axis_tdata[63:32], want[63:32]);
                    end
                    n_checked++;
                end
            end
            m_axis_tready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin : hold_off
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin : stimulus
        int ph, m, stop_at;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, single extreme bytes, a short mixed message
        push_req(OP_FINISH, 8'hA5);
        push_req(OP_APPEND, 8'h00);
        push_req(OP_FINISH, 8'h5A);
        push_req(OP_APPEND, 8'hFF);
        push_req(OP_FINISH, 8'hFF);
        push_req(OP_APPEND, 8'h55);
        push_req(OP_APPEND, 8'hAA);
        push_req(OP_APPEND, 8'h01);
        push_req(OP_APPEND, 8'h80);
        push_req(OP_FINISH, 8'h00);
        push_req(OP_FINISH, 8'h00);
        drain_sent();

        // output held off while short messages keep arriving
        hold_go = 1'b1;
        for (m = 0; m < 8; m++) begin
            queue_message($urandom_range(1, 4));
        end
        drain_sent();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            stop_at = n_queued + PHASE_ITEMS;
            while (n_queued < stop_at) begin
                queue_message(pick_length());
            end
            drain_sent();
        end

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d message bytes and %0d finish requests; %0d digests compared.",
                 n_bytes, n_finish, n_checked);
        $display("Flow control: free running, input gaps, output stalls, both, one long hold.");
        if (n_errors == 0) begin
            $display("speck_davies_meyer_hash64_unit verification clean");
        end else begin
            $display("speck_davies_meyer_hash64_unit verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("speck_davies_meyer_hash64_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/sdmh_pkg.sv
src/speck_davies_meyer_hash64_unit.sv
dv/speck_davies_meyer_hash64_unit_tb.sv
